// ===== rtl/crop_resize_rgb565_to_gray_assert.svh =====
// Assertion macros shared by the block's checks. Each check runs on clk and is
// off while rst is high.
`ifndef CROP_RESIZE_RGB565_TO_GRAY_ASSERT_SVH
`define CROP_RESIZE_RGB565_TO_GRAY_ASSERT_SVH

// Condition must hold at every edge.
`define CRG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence must hold in the same cycle as the trigger.
`define CRG_ASSERT_IMPL(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the trigger.
`define CRG_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/crg_pkg.sv =====
package crg_pkg;

  // Frame geometry limits
  localparam int SRC_MAX = 1024;
  localparam int OUT_MAX = 256;
  localparam int POS_W   = $clog2(SRC_MAX);        // source position
  localparam int OPOS_W  = $clog2(OUT_MAX) + 1;    // output position, holds OUT_MAX
  localparam int SW_W    = 11;                     // source size registers
  localparam int TW_W    = 9;                      // target size registers
  localparam int GAIN_W  = 10;

  // Position divider: source_height * out_pos < SRC_MAX * OUT_MAX
  localparam int DIVD_W  = POS_W + OPOS_W - 1;
  localparam int STEP_W  = $clog2(POS_W);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SW_W;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN_PCT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_GAIN_PCT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN_PCT  = 3'd6;

  // Color math: s = p * Q88_MAX / (max * 100), p = v * gain
  localparam logic [15:0] Q88_MAX = 16'hFF00;
  localparam int PCT      = 100;
  localparam int CH5_SAT  = 31 * PCT;               // p at which 5-bit channel clamps
  localparam int CH6_SAT  = 63 * PCT;
  localparam int CH5_GCD  = 20;
  localparam int CH6_GCD  = 60;
  localparam int CH5_NUM  = 65280 / CH5_GCD;
  localparam int CH5_DEN  = CH5_SAT / CH5_GCD;
  localparam int CH6_NUM  = 65280 / CH6_GCD;
  localparam int CH6_DEN  = CH6_SAT / CH6_GCD;
  localparam int P_W      = 16;                     // v * gain
  localparam int PLOW_W   = 13;                     // p below saturation
  localparam int N_W      = 24;                     // p * NUM below saturation
  localparam int RCP_SHIFT = 32;
  localparam int RCP_W    = 26;
  localparam logic [RCP_W-1:0] CH5_RECIP =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'(CH5_DEN) - 64'd1) / 64'(CH5_DEN));
  localparam logic [RCP_W-1:0] CH6_RECIP =
    RCP_W'(((64'd1 << RCP_SHIFT) + 64'(CH6_DEN) - 64'd1) / 64'(CH6_DEN));

  // Gray weights, Q0.16
  localparam logic [15:0] W_RED   = 16'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;

  // Queues
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic [15:0] pixel_word;
    logic        frame_start;
  } pixel_item_t;

  typedef struct packed {
    logic [15:0] gray_level;
    logic [7:0]  out_col;
    logic [7:0]  out_row;
    logic        frame_last;
  } result_item_t;

  typedef struct packed {
    logic [15:0] pixel_word;
    logic [7:0]  out_col;
    logic [7:0]  out_row;
    logic        frame_last;
  } kept_item_t;

  localparam int SLOT_W = $bits(result_item_t);

  typedef struct packed {
    logic [SW_W-1:0]   source_width;
    logic [SW_W-1:0]   source_height;
    logic [TW_W-1:0]   target_width;
    logic [TW_W-1:0]   target_height;
    logic [GAIN_W-1:0] red_gain_pct;
    logic [GAIN_W-1:0] green_gain_pct;
    logic [GAIN_W-1:0] blue_gain_pct;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    source_width:   11'd320,
    source_height:  11'd240,
    target_width:   9'd48,
    target_height:  9'd48,
    red_gain_pct:   10'd170,
    green_gain_pct: 10'd150,
    blue_gain_pct:  10'd200
  };

  typedef struct packed {
    logic busy;   // wanted position being recomputed
    logic keep;   // accepted pixel is an output sample
  } front_stat_t;

endpackage

// ===== rtl/crg_div.sv =====
module crg_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [crg_pkg::DIVD_W-1:0]  dividend,
  input  logic [crg_pkg::TW_W-1:0]    divisor,
  output logic                        busy,
  output logic                        over,
  output logic [crg_pkg::POS_W-1:0]   quotient
);
  import crg_pkg::*;

  logic [DIVD_W-1:0] rem;
  logic [TW_W-1:0]   dvsr;
  logic [STEP_W-1:0] step;
  logic [DIVD_W:0]   trial;
  logic              fits;

  // Restoring division, one quotient bit per cycle, MSB first
  assign trial = (DIVD_W + 1)'(dvsr) << step;
  assign fits  = {1'b0, rem} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dvsr     <= divisor;
      quotient <= '0;
      step     <= STEP_W'(POS_W - 1);
      // quotient too large for POS_W bits: no source position can match it
      over     <= {1'b0, dividend} >= ((DIVD_W + 1)'(divisor) << POS_W);
    end else if (busy) begin
      if (fits) begin
        rem            <= rem - trial[DIVD_W-1:0];
        quotient[step] <= 1'b1;
      end
      step <= step - 1'b1;
    end
  end

endmodule

// ===== rtl/crg_fifo.sv =====
module crg_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [crg_pkg::SLOT_W-1:0]  wr_data,
  output logic                        full,
  input  logic                        rd_en,
  output logic [crg_pkg::SLOT_W-1:0]  rd_data,
  output logic                        empty,
  output logic [crg_pkg::QCNT_W-1:0]  count
);
  import crg_pkg::*;

  logic [SLOT_W-1:0] slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              do_wr;
  logic              do_rd;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/crg_front.sv =====
module crg_front (
  input  logic                  clk,
  input  logic                  rst,
  input  crg_pkg::cfg_t         cfg,
  input  logic                  recalc,
  input  logic                  accept,
  input  crg_pkg::pixel_item_t  pixel,
  output crg_pkg::front_stat_t  stat,
  output crg_pkg::kept_item_t   kept
);
  import crg_pkg::*;

  logic [POS_W-1:0]  src_col;
  logic [POS_W-1:0]  src_row;
  logic [OPOS_W-1:0] next_out_col;
  logic [OPOS_W-1:0] next_out_row;
  logic              frame_finished;
  logic              wanted_zero;
  logic              launch;

  logic              col_busy;
  logic              row_busy;
  logic              col_over;
  logic              row_over;
  logic [POS_W-1:0]  col_quo;
  logic [POS_W-1:0]  row_quo;
  logic [SW_W+OPOS_W-1:0] col_prod;
  logic [SW_W+OPOS_W-1:0] row_prod;

  logic              fs;
  logic [POS_W-1:0]  cur_col;
  logic [POS_W-1:0]  cur_row;
  logic [OPOS_W-1:0] cur_ocol;
  logic [OPOS_W-1:0] cur_orow;
  logic              cur_fin;
  logic [POS_W-1:0]  wcol;
  logic [POS_W-1:0]  wrow;
  logic              wover;
  logic              sizes_ok;
  logic [SW_W-1:0]   crop;
  logic [SW_W:0]     target_col;
  logic              hit;
  logic [OPOS_W-1:0] col_inc;
  logic [OPOS_W-1:0] row_inc;
  logic              wrap_col;
  logic              wrap_row;
  logic [POS_W:0]    col_step;
  logic              col_wrap;

  // Wanted source positions, recomputed when a kept pixel moves the output position or on a config write
  assign col_prod = (SW_W + OPOS_W)'(cfg.source_height) * (SW_W + OPOS_W)'(next_out_col);
  assign row_prod = (SW_W + OPOS_W)'(cfg.source_height) * (SW_W + OPOS_W)'(next_out_row);

  crg_div u_col_div (
    .clk      (clk),
    .rst      (rst),
    .start    (launch),
    .dividend (col_prod[DIVD_W-1:0]),
    .divisor  (cfg.target_width),
    .busy     (col_busy),
    .over     (col_over),
    .quotient (col_quo)
  );

  crg_div u_row_div (
    .clk      (clk),
    .rst      (rst),
    .start    (launch),
    .dividend (row_prod[DIVD_W-1:0]),
    .divisor  (cfg.target_height),
    .busy     (row_busy),
    .over     (row_over),
    .quotient (row_quo)
  );

  always_comb begin
    fs       = pixel.frame_start;
    cur_col  = fs ? '0 : src_col;
    cur_row  = fs ? '0 : src_row;
    cur_ocol = fs ? '0 : next_out_col;
    cur_orow = fs ? '0 : next_out_row;
    cur_fin  = fs ? 1'b0 : frame_finished;
    wcol     = (fs || wanted_zero) ? '0 : col_quo;
    wrow     = (fs || wanted_zero) ? '0 : row_quo;
    // wanted position beyond any source position after a mid-frame size change
    wover    = !(fs || wanted_zero) && (col_over || row_over);

    sizes_ok = (cfg.source_width != '0) && (cfg.source_height != '0) &&
               (cfg.target_width != '0) && (cfg.target_height != '0) &&
               (cfg.source_width <= SW_W'(SRC_MAX)) &&
               (cfg.target_width <= TW_W'(OUT_MAX)) &&
               (cfg.target_height <= TW_W'(OUT_MAX)) &&
               (cfg.source_height <= cfg.source_width) &&
               (SW_W'(cfg.target_width) <= cfg.source_height) &&
               (SW_W'(cfg.target_height) <= cfg.source_height);

    crop       = (cfg.source_width - cfg.source_height) >> 1;
    target_col = (SW_W + 1)'(crop) + (SW_W + 1)'(wcol);
    hit        = sizes_ok && !cur_fin && !wover && (cur_row == wrow) &&
                 ((SW_W + 1)'(cur_col) == target_col);

    col_inc  = cur_ocol + 1'b1;
    row_inc  = cur_orow + 1'b1;
    wrap_col = col_inc >= cfg.target_width;
    wrap_row = row_inc >= cfg.target_height;

    col_step = (POS_W + 1)'(cur_col) + 1'b1;
    col_wrap = (SW_W'(col_step) >= cfg.source_width) ||
               (col_step >= (POS_W + 1)'(SRC_MAX));
  end

  assign stat.keep       = accept && hit;
  assign stat.busy       = launch || col_busy || row_busy;
  assign kept.pixel_word = pixel.pixel_word;
  assign kept.out_col    = cur_ocol[7:0];
  assign kept.out_row    = cur_orow[7:0];
  assign kept.frame_last = wrap_col && wrap_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col        <= '0;
      src_row        <= '0;
      next_out_col   <= '0;
      next_out_row   <= '0;
      frame_finished <= 1'b0;
      wanted_zero    <= 1'b1;
      launch         <= 1'b0;
    end else begin
      launch <= stat.keep || recalc;
      if (stat.keep || recalc) begin
        wanted_zero <= 1'b0;
      end else if (accept && fs) begin
        wanted_zero <= 1'b1;
      end
      if (accept) begin
        src_col <= col_wrap ? '0 : col_step[POS_W-1:0];
        if (col_wrap && cur_row < POS_W'(SRC_MAX - 1)) begin
          src_row <= cur_row + 1'b1;
        end else begin
          src_row <= cur_row;
        end
        if (hit) begin
          next_out_col   <= wrap_col ? '0 : col_inc;
          next_out_row   <= wrap_col ? (wrap_row ? '0 : row_inc) : cur_orow;
          frame_finished <= wrap_col && wrap_row;
        end else begin
          next_out_col   <= cur_ocol;
          next_out_row   <= cur_orow;
          frame_finished <= cur_fin;
        end
      end
    end
  end

endmodule

// ===== rtl/crg_back.sv =====
module crg_back (
  input  logic                        clk,
  input  logic                        rst,
  input  crg_pkg::cfg_t               cfg,
  input  logic                        src_valid,
  input  crg_pkg::kept_item_t         src,
  output logic                        src_take,
  input  logic [crg_pkg::QCNT_W-1:0]  room_count,
  output logic                        res_valid,
  output crg_pkg::result_item_t       res
);
  import crg_pkg::*;

  typedef struct packed {
    logic [7:0] out_col;
    logic [7:0] out_row;
    logic       frame_last;
  } meta_t;

  logic [3:0]   stage_valid;
  meta_t        meta [4];
  logic [QCNT_W:0] committed;

  logic [P_W-1:0] pr, pg, pb;
  logic           sat_r, sat_g, sat_b;
  logic [N_W-1:0] nr, ng, nb;
  logic [N_W+RCP_W-1:0] mr, mg, mb;
  logic [15:0]    sr, sg, sb;
  logic [31:0]    wr, wg, wb;
  logic [33:0]    sum;
  logic [17:0]    gray_full;

  // Issue only when the result queue has a slot for every sample in flight
  assign committed = (QCNT_W + 1)'(room_count) + (QCNT_W + 1)'($countones(stage_valid));
  assign src_take  = src_valid && (committed < (QCNT_W + 1)'(QUEUE_DEPTH));

  assign mr = (N_W + RCP_W)'(nr) * (N_W + RCP_W)'(CH5_RECIP);
  assign mg = (N_W + RCP_W)'(ng) * (N_W + RCP_W)'(CH6_RECIP);
  assign mb = (N_W + RCP_W)'(nb) * (N_W + RCP_W)'(CH5_RECIP);

  assign sum       = 34'(wr) + 34'(wg) + 34'(wb);
  assign gray_full = sum[33:16];

  assign res_valid      = stage_valid[3];
  assign res.gray_level = (gray_full > 18'(Q88_MAX)) ? Q88_MAX : gray_full[15:0];
  assign res.out_col    = meta[3].out_col;
  assign res.out_row    = meta[3].out_row;
  assign res.frame_last = meta[3].frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= {stage_valid[2:0], src_take};
    end
  end

  always_ff @(posedge clk) begin
    // expand and apply gain
    meta[0] <= '{out_col: src.out_col, out_row: src.out_row, frame_last: src.frame_last};
    pr <= P_W'(src.pixel_word[15:11]) * P_W'(cfg.red_gain_pct);
    pg <= P_W'(src.pixel_word[10:5]) * P_W'(cfg.green_gain_pct);
    pb <= P_W'(src.pixel_word[4:0]) * P_W'(cfg.blue_gain_pct);

    // clamp test and scale numerator
    meta[1] <= meta[0];
    sat_r <= pr >= P_W'(CH5_SAT);
    sat_g <= pg >= P_W'(CH6_SAT);
    sat_b <= pb >= P_W'(CH5_SAT);
    nr <= N_W'(pr[PLOW_W-1:0]) * N_W'(CH5_NUM);
    ng <= N_W'(pg[PLOW_W-1:0]) * N_W'(CH6_NUM);
    nb <= N_W'(pb[PLOW_W-1:0]) * N_W'(CH5_NUM);

    // divide by the channel denominator through its reciprocal
    meta[2] <= meta[1];
    sr <= sat_r ? Q88_MAX : mr[RCP_SHIFT +: 16];
    sg <= sat_g ? Q88_MAX : mg[RCP_SHIFT +: 16];
    sb <= sat_b ? Q88_MAX : mb[RCP_SHIFT +: 16];

    // gray weights
    meta[3] <= meta[2];
    wr <= 32'(sr) * 32'(W_RED);
    wg <= 32'(sg) * 32'(W_GREEN);
    wb <= 32'(sb) * 32'(W_BLUE);
  end

endmodule

// ===== rtl/crop_resize_rgb565_to_gray.sv =====
// Crop, nearest-neighbor downscale and gray conversion of an RGB565 pixel stream.
//
// Input queue: present a pixel on pixel with push; it transfers at an edge with push
// high and full low. Set frame_start on the first pixel of each camera frame.
// Result queue: while empty is low the oldest gray sample sits on result; it
// transfers at an edge with pop high. Results come out in output raster order
// with out_col, out_row and frame_last on the final sample of the image.
// Config port: cfg_write, cfg_index, cfg_data write one size or gain register per
// cycle; write only while no sample is in flight.
// Throughput: one pixel per cycle, except that full rises after every kept pixel
// and every config write while two 10-step restoring dividers rebuild the wanted
// source column and row.
// A kept pixel passes the 8-entry sample queue, the 4-stage color pipeline and
// the result queue on its way to result.
// A stalled receiver fills the 8-entry result queue, then the sample queue,
// and full rises; nothing is dropped. Reset (rst, synchronous) loads the default
// 320x240 -> 48x48 setup and empties both queues.
`include "crop_resize_rgb565_to_gray_assert.svh"

module crop_resize_rgb565_to_gray (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  crg_pkg::pixel_item_t            pixel,
  output logic                            empty,
  input  logic                            pop,
  output crg_pkg::result_item_t           result,
  input  logic                            cfg_write,
  input  logic [crg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import crg_pkg::*;

  cfg_t                cfg;
  logic                accept;
  front_stat_t         front_stat;
  kept_item_t          front_kept;

  logic [SLOT_W-1:0]   mid_rd_data;
  logic                mid_full;
  logic                mid_empty;
  logic [QCNT_W-1:0]   mid_count;
  logic                mid_take;

  logic                back_valid;
  result_item_t        back_res;
  logic [SLOT_W-1:0]   out_rd_data;
  logic                out_full;
  logic [QCNT_W-1:0]   out_count;

  // Hold input while the wanted position is rebuilt or the sample queue is full
  assign full   = front_stat.busy || mid_full;
  assign accept = push && !full;

  // Configuration registers; a write also triggers a recompute of the wanted position
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:   cfg.source_width   <= cfg_data[SW_W-1:0];
        REG_SOURCE_HEIGHT:  cfg.source_height  <= cfg_data[SW_W-1:0];
        REG_TARGET_WIDTH:   cfg.target_width   <= cfg_data[TW_W-1:0];
        REG_TARGET_HEIGHT:  cfg.target_height  <= cfg_data[TW_W-1:0];
        REG_RED_GAIN_PCT:   cfg.red_gain_pct   <= cfg_data[GAIN_W-1:0];
        REG_GREEN_GAIN_PCT: cfg.green_gain_pct <= cfg_data[GAIN_W-1:0];
        REG_BLUE_GAIN_PCT:  cfg.blue_gain_pct  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: track stream position and pick the pixels that land on the output grid
  crg_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .recalc (cfg_write),
    .accept (accept),
    .pixel  (pixel),
    .stat   (front_stat),
    .kept   (front_kept)
  );

  // Sample queue decouples selection from color math
  crg_fifo u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_stat.keep),
    .wr_data (front_kept),
    .full    (mid_full),
    .rd_en   (mid_take),
    .rd_data (mid_rd_data),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  // Back: gain, clamp and gray weighting
  crg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .src_valid  (!mid_empty),
    .src        (kept_item_t'(mid_rd_data)),
    .src_take   (mid_take),
    .room_count (out_count),
    .res_valid  (back_valid),
    .res        (back_res)
  );

  // Result queue absorbs the pipeline when the receiver stalls
  crg_fifo u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (back_valid),
    .wr_data (back_res),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_rd_data),
    .empty   (empty),
    .count   (out_count)
  );

  assign result = result_item_t'(out_rd_data);

  // Checks
  `CRG_ASSERT_IMPL(a_mid_room, front_stat.keep, mid_count != QCNT_W'(QUEUE_DEPTH), "mid overflow")
  `CRG_ASSERT_IMPL(a_out_room, back_valid, !out_full, "pipeline result into full result queue")
  `CRG_ASSERT_NEXT(a_keep_stall, front_stat.keep, full, "input not held during rebuild")
  `CRG_ASSERT_ALWAYS(a_gray_range, empty || result.gray_level <= Q88_MAX, "gray above 255.0")

endmodule

// ===== tb/sv/crop_resize_rgb565_to_gray_tb.sv =====
`timescale 1ns / 1ps

module crop_resize_rgb565_to_gray_tb;
  import crg_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 32;    // sample queue + color pipe + divider rebuild
  localparam int RAND_PIXELS = 220;
  localparam int PLAN_ROWS   = 39;

  typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_LITERAL} check_e;

  // One line of the directed plan: a register write or a pixel transfer.
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [15:0]            word;
    logic                   fs;
    check_e                 chk;
    result_item_t           lit;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  push;
  logic                  full;
  pixel_item_t           pixel;
  logic                  empty;
  logic                  pop;
  result_item_t          result;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  crop_resize_rgb565_to_gray dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow copy of the block: register file and scan state.
  int unsigned src_w, src_h, dst_w, dst_h, gain_r, gain_g, gain_b;
  int unsigned scan_col, scan_row, next_x, next_y;
  bit          image_done;

  // Gray samples still owed by the block, oldest first.
  result_item_t owed_samples[$];

  int unsigned pixels_sent;
  int unsigned samples_checked;
  int unsigned setups_used;
  int unsigned mismatches;
  int unsigned cycles;
  bit          send_burst;
  plan_row_t   plan [PLAN_ROWS];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void reset_shadow();
    src_w = 320; src_h = 240; dst_w = 48; dst_h = 48;
    gain_r = 170; gain_g = 150; gain_b = 200;
    scan_col = 0; scan_row = 0; next_x = 0; next_y = 0;
    image_done = 1'b0;
  endfunction

  function automatic bit sizes_supported();
    if (src_w == 0 || src_h == 0 || dst_w == 0 || dst_h == 0) return 1'b0;
    if (src_w > SRC_MAX || dst_w > OUT_MAX || dst_h > OUT_MAX) return 1'b0;
    if (src_h > src_w || dst_w > src_h || dst_h > src_h) return 1'b0;
    return 1'b1;
  endfunction

  // Expand a channel to 8 bits, apply the percent gain, return Q8.8 with clamp.
  function automatic longint unsigned scale_q88(int unsigned v, int unsigned top,
                                                int unsigned gain);
    longint unsigned s;
    s = (longint'(v) * 255 * longint'(gain) * 256) / (longint'(top) * 100);
    return (s > Q88_MAX) ? longint'(Q88_MAX) : s;
  endfunction

  function automatic logic [15:0] gray_q88(logic [15:0] w);
    longint unsigned sum;
    sum = longint'(W_RED)   * scale_q88(w[15:11], 31, gain_r) +
          longint'(W_GREEN) * scale_q88(w[10:5],  63, gain_g) +
          longint'(W_BLUE)  * scale_q88(w[4:0],   31, gain_b);
    sum = sum >> 16;
    return (sum > Q88_MAX) ? Q88_MAX : 16'(sum);
  endfunction

  // Advance the shadow scan by one pixel; return 1 with the sample if it is kept.
  function automatic bit predict_gray_sample(input pixel_item_t it,
                                             output result_item_t smp);
    int unsigned crop, want_col, want_row, nxt;
    bit          kept;
    kept = 1'b0;
    smp  = '0;
    if (it.frame_start) begin
      scan_col = 0; scan_row = 0; next_x = 0; next_y = 0;
      image_done = 1'b0;
    end
    if (sizes_supported() && !image_done) begin
      crop     = (src_w - src_h) / 2;
      want_col = (src_h * next_x) / dst_w;
      want_row = (src_h * next_y) / dst_h;
      if (scan_row == want_row && scan_col == crop + want_col) begin
        kept = 1'b1;
        smp.gray_level = gray_q88(it.pixel_word);
        smp.out_col    = 8'(next_x);
        smp.out_row    = 8'(next_y);
        next_x++;
        if (next_x >= dst_w) begin
          next_x = 0;
          next_y++;
          if (next_y >= dst_h) begin
            next_y = 0;
            image_done = 1'b1;
            smp.frame_last = 1'b1;
          end
        end
      end
    end
    // Wrap the column at the frame width; saturate the row at the top.
    nxt = scan_col + 1;
    if (nxt >= src_w || nxt >= SRC_MAX) begin
      scan_col = 0;
      if (scan_row < SRC_MAX - 1) scan_row++;
    end else begin
      scan_col = nxt;
    end
    return kept;
  endfunction

  // Drop push, let every owed sample drain, then give the dividers and the
  // sample queue time to go quiet before touching a register.
  task automatic wait_idle();
    push <= 1'b0;
    while (owed_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Hold cfg_write high; the next send_pixel lowers it before presenting its pixel.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    case (idx)
      REG_SOURCE_WIDTH:   src_w  = val & 'h7FF;
      REG_SOURCE_HEIGHT:  src_h  = val & 'h7FF;
      REG_TARGET_WIDTH:   dst_w  = val & 'h1FF;
      REG_TARGET_HEIGHT:  dst_h  = val & 'h1FF;
      REG_RED_GAIN_PCT:   gain_r = val & 'h3FF;
      REG_GREEN_GAIN_PCT: gain_g = val & 'h3FF;
      REG_BLUE_GAIN_PCT:  gain_b = val & 'h3FF;
      default: ;
    endcase
  endtask

  task automatic write_setup(input int unsigned sw, sh, tw, th, rg, gg, bg);
    write_reg(REG_SOURCE_WIDTH, sw);
    write_reg(REG_SOURCE_HEIGHT, sh);
    write_reg(REG_TARGET_WIDTH, tw);
    write_reg(REG_TARGET_HEIGHT, th);
    write_reg(REG_RED_GAIN_PCT, rg);
    write_reg(REG_GREEN_GAIN_PCT, gg);
    write_reg(REG_BLUE_GAIN_PCT, bg);
    setups_used++;
  endtask

  // Present one pixel, wait for its transfer, then log what the block owes.
  task automatic send_pixel(input logic [15:0] word, input bit fs, input check_e chk,
                            input result_item_t lit);
    int unsigned  gap;
    bit           hold;
    bit           kept;
    pixel_item_t  it;
    result_item_t smp;
    gap  = send_burst ? 0 : $urandom_range(0, 12);
    // Now and then starve the block completely before the next transfer.
    hold = ($urandom_range(0, 39) == 0) || (pixels_sent % 250 == 249);
    it.pixel_word  = word;
    it.frame_start = fs;
    cfg_write <= 1'b0;
    if (hold || gap > 0) push <= 1'b0;
    if (hold) while (owed_samples.size() != 0) @(posedge clk);
    repeat (gap) @(posedge clk);
    pixel <= it;
    push  <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    kept = predict_gray_sample(it, smp);
    pixels_sent++;
    case (chk)
      CHK_MODEL:   if (kept) owed_samples.push_back(smp);
      CHK_LITERAL: owed_samples.push_back(lit);
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gain();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1023;
      2:       return 100;
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  // Receiver: stall at random, with calm stretches that pop every cycle.
  initial begin
    int unsigned  stall;
    bit           calm;
    result_item_t want;
    calm = 1'b0;
    pop <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (owed_samples.size() == 0) begin
        mismatches++;
        if (mismatches < 40)
          $display("%t: unexpected sample gray=%0d col=%0d row=%0d last=%0d", $time,
                   result.gray_level, result.out_col, result.out_row, result.frame_last);
      end else begin
        want = owed_samples.pop_front();
        samples_checked++;
        if (result.gray_level !== want.gray_level || result.out_col !== want.out_col ||
            result.out_row !== want.out_row || result.frame_last !== want.frame_last) begin
          mismatches++;
          if (mismatches < 40)
            $display("%t: sample mismatch expected gray=%0d col=%0d row=%0d last=%0d, %s",
                     $time, want.gray_level, want.out_col, want.out_row, want.frame_last,
                     $sformatf("actual gray=%0d col=%0d row=%0d last=%0d",
                               result.gray_level, result.out_col, result.out_row,
                               result.frame_last));
        end
      end
      if ($urandom_range(0, 31) == 0) calm = ~calm;
    end
  end

  // Sender: reset, defaults, directed plan, row saturation, then random setups.
  initial begin
    int unsigned sw, sh, tw, th, span, len, frames, rand_pixels, phase;
    bit          fs;
    bit          need_idle;
    logic [15:0] word;

    rst       <= 1'b1;
    push      <= 1'b0;
    pixel     <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    pixels_sent = 0;
    samples_checked = 0;
    setups_used = 0;
    mismatches = 0;
    send_burst = 1'b0;
    reset_shadow();

    plan = '{
      // Smallest geometry, gains at the top: every frame start is a full image.
      '{ROW_CONFIG, REG_SOURCE_WIDTH,   16'd1,    1'b0, CHK_MODEL,   '0},
      '{ROW_CONFIG, REG_SOURCE_HEIGHT,  16'd1,    1'b0, CHK_MODEL,   '0},
      '{ROW_CONFIG, REG_TARGET_WIDTH,   16'd1,    1'b0, CHK_MODEL,   '0},
      '{ROW_CONFIG, REG_TARGET_HEIGHT,  16'd1,    1'b0, CHK_MODEL,   '0},
      '{ROW_CONFIG, REG_RED_GAIN_PCT,   16'd1023, 1'b0, CHK_MODEL,   '0},
      '{ROW_CONFIG, REG_GREEN_GAIN_PCT, 16'd1023, 1'b0, CHK_MODEL,   '0},
      '{ROW_CONFIG, REG_BLUE_GAIN_PCT,  16'd1023, 1'b0, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'hFFFF, 1'b1, CHK_LITERAL, '{16'hFF00, 8'd0, 8'd0, 1'b1}},
      // Image already complete: nothing until the next frame start.
      '{ROW_PIXEL,  '0, 16'h1234, 1'b0, CHK_NONE,    '0},
      '{ROW_PIXEL,  '0, 16'h0000, 1'b1, CHK_LITERAL, '{16'h0000, 8'd0, 8'd0, 1'b1}},
      // Zero gains black out even a white pixel.
      '{ROW_CONFIG, REG_RED_GAIN_PCT,   16'd0,    1'b0, CHK_MODEL,   '0},
      '{ROW_CONFIG, REG_GREEN_GAIN_PCT, 16'd0,    1'b0, CHK_MODEL,   '0},
      '{ROW_CONFIG, REG_BLUE_GAIN_PCT,  16'd0,    1'b0, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'hFFFF, 1'b1, CHK_LITERAL, '{16'h0000, 8'd0, 8'd0, 1'b1}},
      '{ROW_CONFIG, REG_RED_GAIN_PCT,   16'd100,  1'b0, CHK_MODEL,   '0},
      '{ROW_CONFIG, REG_GREEN_GAIN_PCT, 16'd100,  1'b0, CHK_MODEL,   '0},
      '{ROW_CONFIG, REG_BLUE_GAIN_PCT,  16'd100,  1'b0, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'hF800, 1'b1, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'h07E0, 1'b1, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'h001F, 1'b1, CHK_MODEL,   '0},
      // Unsupported geometry: zero target, target over the limit after masking,
      // source over the limit, crop taller than the frame.
      '{ROW_CONFIG, REG_TARGET_WIDTH,   16'd0,    1'b0, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'hABCD, 1'b1, CHK_NONE,    '0},
      '{ROW_CONFIG, REG_TARGET_WIDTH,   16'h07FF, 1'b0, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'h5555, 1'b1, CHK_NONE,    '0},
      '{ROW_CONFIG, REG_TARGET_WIDTH,   16'd1,    1'b0, CHK_MODEL,   '0},
      '{ROW_CONFIG, REG_SOURCE_WIDTH,   16'h07FF, 1'b0, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'hFFFF, 1'b1, CHK_NONE,    '0},
      '{ROW_CONFIG, REG_SOURCE_WIDTH,   16'd2,    1'b0, CHK_MODEL,   '0},
      '{ROW_CONFIG, REG_SOURCE_HEIGHT,  16'd3,    1'b0, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'hAAAA, 1'b1, CHK_NONE,    '0},
      // 2x2 kept whole; a frame start in mid-image restarts the scan.
      '{ROW_CONFIG, REG_SOURCE_HEIGHT,  16'd2,    1'b0, CHK_MODEL,   '0},
      '{ROW_CONFIG, REG_TARGET_WIDTH,   16'd2,    1'b0, CHK_MODEL,   '0},
      '{ROW_CONFIG, REG_TARGET_HEIGHT,  16'd2,    1'b0, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'h1111, 1'b1, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'h2222, 1'b0, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'h3333, 1'b1, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'h4444, 1'b0, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'h5555, 1'b0, CHK_MODEL,   '0},
      '{ROW_PIXEL,  '0, 16'h6666, 1'b0, CHK_MODEL,   '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults with no frame start yet: the start of the first source
    // row of the 320x240 frame yields the first samples of the 48x48 image,
    // from column 40 on.
    for (int n = 0; n < 60; n++) send_pixel(16'($urandom), 1'b0, CHK_MODEL, '0);

    // Walk the directed plan; drain before each group of register writes.
    need_idle = 1'b1;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CONFIG) begin
        if (need_idle) wait_idle();
        need_idle = 1'b0;
        write_reg(plan[i].reg_idx, plan[i].word);
      end else begin
        send_pixel(plan[i].word, plan[i].fs, plan[i].chk, plan[i].lit);
        need_idle = 1'b1;
      end
    end

    // Row saturation: run 1024 rows of a one-pixel-wide frame under an
    // unsupported target so nothing is kept, then make the target legal.
    // A saturated row counter sits at the last row and keeps nothing; a
    // wrapped one would be back at row zero.
    send_burst = 1'b1;
    wait_idle();
    write_setup(1, 1, 2, 1, pick_gain(), pick_gain(), pick_gain());
    send_pixel(16'($urandom), 1'b1, CHK_MODEL, '0);
    for (int n = 0; n < 1023; n++) send_pixel(16'($urandom), 1'b0, CHK_MODEL, '0);
    wait_idle();
    write_reg(REG_TARGET_WIDTH, 1);
    send_pixel(16'($urandom), 1'b0, CHK_MODEL, '0);
    send_pixel(16'($urandom), 1'b1, CHK_MODEL, '0);

    // Random setups: mostly legal small geometries with whole frames, the
    // largest sizes only briefly, and a share of illegal ones.
    rand_pixels = 0;
    phase = 0;
    while (rand_pixels < RAND_PIXELS) begin
      send_burst = ($urandom_range(0, 3) == 0);
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, sw);
      tw = $urandom_range(1, sh);
      th = $urandom_range(1, sh);
      span = 0;
      if (phase == 0) begin
        sw = SRC_MAX; sh = SRC_MAX; tw = OUT_MAX; th = OUT_MAX; span = 48;
      end else if (phase == 1) begin
        sw = OUT_MAX; sh = OUT_MAX; tw = OUT_MAX; th = OUT_MAX; span = 70;
      end else if ($urandom_range(0, 9) == 0) begin
        span = $urandom_range(4, 40);
        case ($urandom_range(0, 7))
          0:       sw = 0;
          1:       sh = 0;
          2:       tw = 0;
          3:       th = 0;
          4:       sh = sw + $urandom_range(1, 4);
          5:       tw = sh + $urandom_range(1, 4);
          6:       sw = $urandom_range(SRC_MAX + 1, 2047);
          default: th = $urandom_range(OUT_MAX + 1, 511);
        endcase
      end
      wait_idle();
      write_setup(sw, sh, tw, th, pick_gain(), pick_gain(), pick_gain());
      frames = (span != 0) ? 1 : $urandom_range(1, 3);
      repeat (frames) begin
        len = (span != 0) ? span : sw * sh;
        // Cut some frames short, pad others with pixels past the image.
        if (span == 0 && $urandom_range(0, 7) == 0) len = $urandom_range(1, len);
        if ($urandom_range(0, 3) == 0) len += $urandom_range(1, 4);
        for (int n = 0; n < len; n++) begin
          fs = (n == 0) && ($urandom_range(0, 15) != 0);
          case ($urandom_range(0, 15))
            0:       word = 16'hFFFF;
            1:       word = 16'h0000;
            default: word = 16'($urandom);
          endcase
          send_pixel(word, fs, CHK_MODEL, '0);
        end
        rand_pixels += len;
      end
      phase++;
    end

    wait_idle();
    $display("Sent %0d pixels over %0d register setups, checked %0d gray samples.",
             pixels_sent, setups_used, samples_checked);
    $display("Covered default, extreme and illegal geometries and gains; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/crg_pkg.sv
rtl/crg_div.sv
rtl/crg_fifo.sv
rtl/crg_front.sv
rtl/crg_back.sv
rtl/crop_resize_rgb565_to_gray.sv
tb/sv/crop_resize_rgb565_to_gray_tb.sv
